[design/cpts_pkg.sv]
// ----------------------------------------------------------------------------
// Scheduler package
// Shared constants and types for the counter priority task scheduler: the
// command broadcast to every task cell and the scan word passed down the row.
// ----------------------------------------------------------------------------
package cpts_pkg;

  localparam int NUM_TASKS      = 64;
  localparam int COUNTER_BITS   = 10;
  localparam int IDX_W          = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int PRIO_W         = 8;
  localparam int DEPTH_W        = 4;
  localparam int SLOT_BITS      = 6;
  localparam int CNT_FIELD_BITS = 10;

  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_LOAD      = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_SET_RUN   = 3'd3,
    OP_DEC       = 3'd4,
    OP_DEPTH_INC = 3'd5,
    OP_DEPTH_DEC = 3'd6
  } cell_op_e;

  typedef struct packed {
    cell_op_e                op;
    logic [IDX_W-1:0]        idx;
    logic                    runnable;
    logic [PRIO_W-1:0]       prio;
    logic [COUNTER_BITS-1:0] counter;
  } cmd_t;

  typedef struct packed {
    logic                    pulse;
    logic                    recharge;
    logic                    found;
    logic [COUNTER_BITS-1:0] top;
    logic [IDX_W-1:0]        best;
  } scan_t;

endpackage

[design/counter_priority_task_scheduler_top.sv]
// ----------------------------------------------------------------------------
// Counter priority task scheduler
// Row of task cells with a small sequencer that issues requests to the cells
// and runs the best-task scan down the row.
// ----------------------------------------------------------------------------
// Usage: requests enter on the in channel (in_valid_i, in_stall_o) and one
// response leaves on the out channel (out_valid_o, out_stall_i) per request.
// A request is taken while the sequencer is idle; in_stall_o is high while a
// request is being handled.
// Sequence: a request that does not reschedule passes S_EXEC, S_CHECK and
// S_DONE before the response register. A tick that reschedules adds one
// scan of the row in S_PASS1, and a second scan with recharge in S_PASS2
// when every runnable counter is zero. The scan pulse moves one cell per
// cycle.
// Throughput: one request at a time; the next one may be taken while the
// previous response still waits in the output register.
// Reset clears all slots to absent, all preemption depths and the current
// slot to zero. While out_stall_i holds a response, a finished request waits
// in its final state and the response register keeps its value.
// ----------------------------------------------------------------------------
module counter_priority_task_scheduler_top import cpts_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                req_type_i,
  input  logic [SLOT_BITS-1:0]      slot_i,
  input  logic                      runnable_i,
  input  logic [PRIO_W-1:0]         priority_req_i,
  input  logic [CNT_FIELD_BITS-1:0] initial_counter_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [SLOT_BITS-1:0]      current_slot_o,
  output logic                      switched_o,
  output logic [1:0]                status_o,
  output logic [CNT_FIELD_BITS-1:0] current_counter_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_PASS1,
    S_PASS2,
    S_DONE
  } state_e;

  localparam logic [2:0] REQ_TICK      = 3'd0;
  localparam logic [2:0] REQ_LOAD      = 3'd1;
  localparam logic [2:0] REQ_REMOVE    = 3'd2;
  localparam logic [2:0] REQ_SET_RUN   = 3'd3;
  localparam logic [2:0] REQ_PREEMPT_D = 3'd4;
  localparam logic [2:0] REQ_PREEMPT_E = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_STALL = 2'd2;

  state_e                  state_q;
  cmd_t                    cmd_q, cmd_req;
  scan_t                   scan_in_q;
  logic [IDX_W-1:0]        cur_q, prev_q;
  logic                    tick_q;
  logic [1:0]              stat_q;
  logic                    out_valid_q;
  logic [SLOT_BITS-1:0]    out_slot_q;
  logic                    out_switched_q;
  logic [1:0]              out_status_q;
  logic [CNT_FIELD_BITS-1:0] out_counter_q;

  scan_t                   chain [NUM_TASKS+1];
  logic [COUNTER_BITS-1:0] cell_cnt [NUM_TASKS];
  logic [DEPTH_W-1:0]      cell_depth [NUM_TASKS];

  logic                    slot_ok;
  logic                    in_acc;
  logic                    out_free;
  scan_t                   scan_res;

  assign chain[0] = scan_in_q;
  assign scan_res = chain[NUM_TASKS];

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    cpts_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (IDX_W'(i)),
      .cmd_i     (cmd_q),
      .scan_i    (chain[i]),
      .scan_o    (chain[i+1]),
      .counter_o (cell_cnt[i]),
      .depth_o   (cell_depth[i])
    );
  end

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign slot_ok  = (32'(slot_i) < NUM_TASKS);

  always_comb begin
    cmd_req          = '0;
    cmd_req.op       = OP_NONE;
    cmd_req.idx      = cur_q;
    cmd_req.runnable = runnable_i;
    cmd_req.prio     = priority_req_i;
    cmd_req.counter  = COUNTER_BITS'(initial_counter_i);
    case (req_type_i)
      REQ_TICK:      cmd_req.op = OP_DEC;
      REQ_LOAD: begin
        cmd_req.op  = slot_ok ? OP_LOAD : OP_NONE;
        cmd_req.idx = IDX_W'(slot_i);
      end
      REQ_REMOVE: begin
        cmd_req.op  = slot_ok ? OP_REMOVE : OP_NONE;
        cmd_req.idx = IDX_W'(slot_i);
      end
      REQ_SET_RUN: begin
        cmd_req.op  = slot_ok ? OP_SET_RUN : OP_NONE;
        cmd_req.idx = IDX_W'(slot_i);
      end
      REQ_PREEMPT_D: cmd_req.op = OP_DEPTH_INC;
      REQ_PREEMPT_E: cmd_req.op = OP_DEPTH_DEC;
      default:       cmd_req.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cmd_q          <= '0;
      scan_in_q      <= '0;
      cur_q          <= '0;
      prev_q         <= '0;
      tick_q         <= 1'b0;
      stat_q         <= STAT_OK;
      out_valid_q    <= 1'b0;
      out_slot_q     <= '0;
      out_switched_q <= 1'b0;
      out_status_q   <= STAT_OK;
      out_counter_q  <= '0;
    end else begin
      if (scan_in_q.pulse) scan_in_q.pulse <= 1'b0;
      if (state_q != S_DONE && out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cmd_q   <= cmd_req;
            prev_q  <= cur_q;
            tick_q  <= (req_type_i == REQ_TICK);
            stat_q  <= STAT_OK;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          cmd_q.op <= OP_NONE;
          state_q  <= S_CHECK;
        end
        S_CHECK: begin
          if (tick_q && cell_cnt[cur_q] == '0 && cell_depth[cur_q] == '0) begin
            scan_in_q <= '{pulse: 1'b1, recharge: 1'b0, found: 1'b0,
                           top: '0, best: '0};
            state_q   <= S_PASS1;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_PASS1: begin
          if (scan_res.pulse) begin
            if (!scan_res.found) begin
              cur_q   <= '0;
              stat_q  <= STAT_EMPTY;
              state_q <= S_DONE;
            end else if (scan_res.top != '0) begin
              cur_q   <= scan_res.best;
              state_q <= S_DONE;
            end else begin
              scan_in_q <= '{pulse: 1'b1, recharge: 1'b1, found: 1'b0,
                             top: '0, best: '0};
              state_q   <= S_PASS2;
            end
          end
        end
        S_PASS2: begin
          if (scan_res.pulse) begin
            if (scan_res.top == '0) begin
              stat_q <= STAT_STALL;
            end else begin
              cur_q <= scan_res.best;
            end
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            out_slot_q     <= SLOT_BITS'(cur_q);
            out_switched_q <= (cur_q != prev_q);
            out_status_q   <= stat_q;
            out_counter_q  <= CNT_FIELD_BITS'(cell_cnt[cur_q]);
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign current_slot_o    = out_slot_q;
  assign switched_o        = out_switched_q;
  assign status_o          = out_status_q;
  assign current_counter_o = out_counter_q;

endmodule

[design/cpts_cell.sv]
// ----------------------------------------------------------------------------
// Task cell
// Holds one task slot. Applies broadcast commands aimed at its slot and, when
// the scan pulse passes, optionally recharges its counter and folds itself
// into the running best pick before handing the scan word on.
// ----------------------------------------------------------------------------
module cpts_cell import cpts_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [IDX_W-1:0]        idx_i,
  input  cmd_t                    cmd_i,
  input  scan_t                   scan_i,
  output scan_t                   scan_o,
  output logic [COUNTER_BITS-1:0] counter_o,
  output logic [DEPTH_W-1:0]      depth_o
);

  localparam int SUM_W = ((COUNTER_BITS > PRIO_W) ? COUNTER_BITS : PRIO_W) + 1;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
  localparam logic [DEPTH_W-1:0]      DEPTH_MAX = '1;

  logic                    present_q, present_d;
  logic                    runnable_q, runnable_d;
  logic [PRIO_W-1:0]       prio_q, prio_d;
  logic [COUNTER_BITS-1:0] cnt_q, cnt_d;
  logic [DEPTH_W-1:0]      depth_q, depth_d;
  scan_t                   scan_q, scan_d;

  logic                    hit;
  logic [SUM_W-1:0]        sum;
  logic [COUNTER_BITS-1:0] recharged;
  logic [COUNTER_BITS-1:0] scan_val;

  always_comb begin
    hit       = (cmd_i.idx == idx_i);
    sum       = SUM_W'(cnt_q >> 1) + SUM_W'(prio_q);
    recharged = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : COUNTER_BITS'(sum);
    scan_val  = scan_i.recharge ? recharged : cnt_q;

    present_d  = present_q;
    runnable_d = runnable_q;
    prio_d     = prio_q;
    cnt_d      = cnt_q;
    depth_d    = depth_q;

    if (hit) begin
      case (cmd_i.op)
        OP_LOAD: begin
          present_d  = 1'b1;
          runnable_d = cmd_i.runnable;
          prio_d     = cmd_i.prio;
          cnt_d      = cmd_i.counter;
          depth_d    = '0;
        end
        OP_REMOVE: begin
          present_d  = 1'b0;
          runnable_d = 1'b0;
        end
        OP_SET_RUN: begin
          if (present_q) runnable_d = cmd_i.runnable;
        end
        OP_DEC: begin
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
        end
        OP_DEPTH_INC: begin
          if (depth_q != DEPTH_MAX) depth_d = depth_q + 1'b1;
        end
        OP_DEPTH_DEC: begin
          if (depth_q != '0) depth_d = depth_q - 1'b1;
        end
        default: begin
        end
      endcase
    end

    scan_d = scan_i;
    if (scan_i.pulse) begin
      if (scan_i.recharge && present_q) cnt_d = recharged;
      if (present_q && runnable_q && (!scan_i.found || scan_val > scan_i.top)) begin
        scan_d.found = 1'b1;
        scan_d.top   = scan_val;
        scan_d.best  = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= 1'b0;
      runnable_q <= 1'b0;
      depth_q    <= '0;
      scan_q     <= '0;
    end else begin
      present_q  <= present_d;
      runnable_q <= runnable_d;
      depth_q    <= depth_d;
      scan_q     <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    cnt_q  <= cnt_d;
  end

  assign scan_o    = scan_q;
  assign counter_o = cnt_q;
  assign depth_o   = depth_q;

endmodule
